### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is low.
`define GEQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also holds through reset.
`define GEQ_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/geq_pkg.sv
`default_nettype none
package geq_pkg;

    localparam int MAX_BANDS  = 31;
    localparam int HIST_FRAC  = 16;
    localparam int BAND_W     = $clog2(MAX_BANDS);
    localparam int TBL_DEPTH  = MAX_BANDS * 4;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int HIST_DEPTH = MAX_BANDS * 6;   // band x channel x 3 slots
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int BANDS_LO   = (MAX_BANDS < 10) ? MAX_BANDS : 10;
    localparam int BANDS_HI   = (MAX_BANDS < 31) ? MAX_BANDS : 31;

    // table word codes
    localparam logic [1:0] W_ALPHA = 2'd0;
    localparam logic [1:0] W_BETA  = 2'd1;
    localparam logic [1:0] W_GAMMA = 2'd2;
    localparam logic [1:0] W_GAIN  = 2'd3;

    // config register indexes
    localparam logic CFG_BAND_MODE = 1'b0;
    localparam logic CFG_EXTRA     = 1'b1;

    // action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TABLE  = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               last_of_buffer;
        logic [4:0]         band_index;
        logic [1:0]         word_select;
        logic signed [31:0] word_value;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               last_of_buffer_out;
    } t_out_word;

    // MAC step controls
    typedef struct packed {
        logic mul_lo;   // low 24 bits of operand
        logic mul_hi;   // high 25 bits of operand
        logic fin;      // combine and round
    } t_mac_ctl;

    localparam logic signed [63:0] HIST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] HIST_MIN = -HIST_MAX - 64'sd1;
    localparam logic signed [63:0] ONE      = 64'sd1 <<< HIST_FRAC;
    localparam logic signed [63:0] OUT_LO   = -64'sd32768 * ONE;
    localparam logic signed [63:0] OUT_HI   = 64'sd32767 * ONE;
    localparam logic signed [63:0] HALF     = ONE >>> 1;

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > HIST_MAX) begin
            r = HIST_MAX[47:0];
        end else if (v < HIST_MIN) begin
            r = HIST_MIN[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/geq_ram.sv
`default_nettype none
module geq_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/geq_mac.sv
`default_nettype none
// round(coef * h / 2^28) half up, in two 32x25 multiplies plus a combine step
module geq_mac (
    input  wire logic                 i_clk,
    input  wire geq_pkg::t_mac_ctl    i_ctl,
    input  wire logic signed [31:0]   i_coef,
    input  wire logic signed [48:0]   i_h,
    output logic signed [53:0]        o_q
);
    import geq_pkg::*;

    logic signed [24:0] op;
    logic signed [56:0] prod;
    logic signed [56:0] r_mul;
    logic signed [56:0] r_prod;
    logic signed [81:0] full;

    assign op   = i_ctl.mul_lo ? $signed({1'b0, i_h[23:0]}) : $signed(i_h[48:24]);
    assign prod = i_coef * op;
    assign full = 82'(r_prod) + (82'(r_mul) <<< 24);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_lo || i_ctl.mul_hi) begin
            r_mul <= prod;
        end
        if (i_ctl.mul_hi) begin
            r_prod <= r_mul + 57'sd134217728;   // + 2^27 rounding
        end
        if (i_ctl.fin) begin
            o_q <= full[81:28];
        end
    end
endmodule
`default_nettype wire

### hdl/graphic_equalizer_iir_bank.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// sample    in         i_valid / o_stall    i_word  (t_in_word)
// result    out        o_valid / i_stall    o_word  (t_out_word)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A table word is written as it is accepted. A sample pair runs one band section
// per band, channel and pass (one pass, or two in extra mode) in 10-band or
// 31-band mode; each coefficient product uses the one 32x25 multiplier of
// geq_mac twice. Reset (synchronous, low) and every band_mode write run a pass
// that zeroes all four history RAMs; input is held off meanwhile and during the
// cycle of any config write. A waiting result in the output register does not
// hold off input; a finished pair waits only while the previous word is stalled.
module graphic_equalizer_iir_bank (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire geq_pkg::t_in_word  i_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output geq_pkg::t_out_word      o_word,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic               i_cfg_data
);
    import geq_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;   // issue alpha, x[n-2], y[n-1]
    localparam logic [3:0] S_LD   = 4'd2;   // store x[n], form x[n]-x[n-2]
    localparam logic [3:0] S_ML   = 4'd3;
    localparam logic [3:0] S_MH   = 4'd4;
    localparam logic [3:0] S_AC   = 4'd5;
    localparam logic [3:0] S_Y    = 4'd6;   // saturate and store y[n]
    localparam logic [3:0] S_SUM  = 4'd7;   // add weighted band output
    localparam logic [3:0] S_DRY  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_CLR  = 4'd11;  // zero the history RAMs

    logic [3:0]          r_state;
    logic [BAND_W-1:0]   r_band;
    logic                r_ch;
    logic                r_pass;
    logic [1:0]          r_k;       // which product: alpha, gamma, beta, gain
    logic [1:0]          r_phase;
    logic                r_band_mode;
    logic                r_extra;
    logic [HIST_AW-1:0]  r_clr;

    logic signed [15:0]  r_smp_l, r_smp_r;
    logic                r_last;
    logic signed [31:0]  r_coef;
    logic signed [48:0]  r_h;
    logic signed [47:0]  r_y1, r_y2;
    logic signed [55:0]  r_sec;
    logic signed [63:0]  r_acc;
    logic signed [15:0]  r_res_l, r_res_r;
    logic                r_ovalid;
    t_out_word           r_out;

    // sample accept and table write
    logic in_acc, smp_acc, tbl_we;
    assign o_stall = (r_state != S_IDLE) || i_cfg_we;
    assign in_acc  = i_valid && !o_stall;
    assign smp_acc = in_acc && (i_word.action == ACT_SAMPLE);
    assign tbl_we  = in_acc && (i_word.action == ACT_TABLE)
                     && ({1'b0, i_word.band_index} < 6'(MAX_BANDS));

    // ring slots
    logic [1:0] cur, prev, prev2;
    assign cur   = r_phase;
    assign prev  = (r_phase == 2'd0) ? 2'd2 : r_phase - 2'd1;
    assign prev2 = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;

    logic [HIST_AW-1:0] base, a_cur, a_prev, a_prev2, x_raddr, y_raddr;
    assign base    = HIST_AW'(r_band) * HIST_AW'(6) + HIST_AW'(r_ch) * HIST_AW'(3);
    assign a_cur   = base + HIST_AW'(cur);
    assign a_prev  = base + HIST_AW'(prev);
    assign a_prev2 = base + HIST_AW'(prev2);
    assign x_raddr = a_prev2;
    assign y_raddr = (r_state == S_RD) ? a_prev : a_prev2;

    // table read address follows the product in flight
    logic [1:0]        word_sel;
    logic [TBL_AW-1:0] tbl_raddr, tbl_waddr;
    logic [31:0]       tbl_q;
    always_comb begin
        case (r_k)
            2'd0:    word_sel = W_GAMMA;
            2'd1:    word_sel = W_BETA;
            default: word_sel = W_GAIN;
        endcase
        if (r_state == S_RD) begin
            word_sel = W_ALPHA;
        end
    end
    assign tbl_raddr = {r_band, word_sel};
    assign tbl_waddr = {BAND_W'(i_word.band_index), i_word.word_select};

    geq_ram #(.W(32), .DEPTH(TBL_DEPTH)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_word.word_value),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_q)
    );

    // histories: one RAM per pass and kind
    logic signed [63:0] xin64;
    logic signed [47:0] xs, y_new;
    logic signed [47:0] x1_q, x2_q, y1_q, y2_q, xp2, yrd;
    logic               x_we, y_we;
    logic signed [53:0] q;
    logic signed [55:0] ysum;

    // clearing pass shares the write ports
    logic               clearing;
    logic [HIST_AW-1:0] h_waddr;
    logic signed [47:0] x_wd, y_wd;

    assign xin64 = r_pass ? r_acc
                          : (64'(r_ch ? r_smp_r : r_smp_l) <<< HIST_FRAC);
    assign xs    = sat48(xin64);
    assign xp2   = r_pass ? x2_q : x1_q;
    assign yrd   = r_pass ? y2_q : y1_q;
    assign ysum  = r_sec - 56'(q);
    assign y_new = sat48(64'(ysum));
    assign x_we  = (r_state == S_LD);
    assign y_we  = (r_state == S_Y);

    assign clearing = (r_state == S_CLR);
    assign h_waddr  = clearing ? r_clr : a_cur;
    assign x_wd     = clearing ? 48'sd0 : xs;
    assign y_wd     = clearing ? 48'sd0 : y_new;

    geq_ram #(.W(48), .DEPTH(HIST_DEPTH)) u_x1 (
        .i_clk(i_clk), .i_we((x_we && !r_pass) || clearing), .i_waddr(h_waddr),
        .i_wdata(x_wd), .i_raddr(x_raddr), .o_rdata(x1_q)
    );
    geq_ram #(.W(48), .DEPTH(HIST_DEPTH)) u_y1 (
        .i_clk(i_clk), .i_we((y_we && !r_pass) || clearing), .i_waddr(h_waddr),
        .i_wdata(y_wd), .i_raddr(y_raddr), .o_rdata(y1_q)
    );
    geq_ram #(.W(48), .DEPTH(HIST_DEPTH)) u_x2 (
        .i_clk(i_clk), .i_we((x_we && r_pass) || clearing), .i_waddr(h_waddr),
        .i_wdata(x_wd), .i_raddr(x_raddr), .o_rdata(x2_q)
    );
    geq_ram #(.W(48), .DEPTH(HIST_DEPTH)) u_y2 (
        .i_clk(i_clk), .i_we((y_we && r_pass) || clearing), .i_waddr(h_waddr),
        .i_wdata(y_wd), .i_raddr(y_raddr), .o_rdata(y2_q)
    );

    // shared multiplier
    t_mac_ctl mac_ctl;
    assign mac_ctl.mul_lo = (r_state == S_ML);
    assign mac_ctl.mul_hi = (r_state == S_MH);
    assign mac_ctl.fin    = (r_state == S_AC);

    geq_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_coef (r_coef),
        .i_h    (r_h),
        .o_q    (q)
    );

    // band loop bounds and output finishing
    logic [BAND_W-1:0]  last_band;
    logic signed [63:0] dry, rnd;
    logic signed [15:0] fin_val;
    assign last_band = r_band_mode ? BAND_W'(BANDS_HI - 1) : BAND_W'(BANDS_LO - 1);
    assign dry       = (64'(r_ch ? r_smp_r : r_smp_l) <<< HIST_FRAC) >>> 2;
    assign rnd       = (r_acc + HALF) >>> HIST_FRAC;
    always_comb begin
        if (r_acc < OUT_LO) begin
            fin_val = -16'sd32768;
        end else if (r_acc > OUT_HI) begin
            fin_val = 16'sd32767;
        end else begin
            fin_val = rnd[15:0];
        end
    end

    logic out_free, clr_req, out_load;
    assign out_free = !r_ovalid || !i_stall;
    assign clr_req  = i_cfg_we && (i_cfg_idx == CFG_BAND_MODE);
    assign out_load = (r_state == S_OUT) && out_free && !clr_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_phase     <= 2'd0;
            r_band_mode <= 1'b0;
            r_extra     <= 1'b0;
            r_ovalid    <= 1'b0;
            r_band      <= '0;
            r_ch        <= 1'b0;
            r_pass      <= 1'b0;
            r_k         <= 2'd0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BAND_MODE) begin
                    r_band_mode <= i_cfg_data;
                end else begin
                    r_extra <= i_cfg_data;
                end
            end
            if (clr_req) begin
                r_clr   <= '0;
                r_state <= S_CLR;
            end else begin
                case (r_state)
                    S_CLR: begin
                        r_clr <= r_clr + HIST_AW'(1);
                        if (r_clr == HIST_AW'(HIST_DEPTH - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (smp_acc) begin
                            r_smp_l <= i_word.left_sample;
                            r_smp_r <= i_word.right_sample;
                            r_last  <= i_word.last_of_buffer;
                            r_band  <= '0;
                            r_ch    <= 1'b0;
                            r_pass  <= 1'b0;
                            r_acc   <= '0;
                            r_state <= S_RD;
                        end
                    end
                    S_RD: begin
                        r_k     <= 2'd0;
                        r_state <= S_LD;
                    end
                    S_LD: begin
                        r_coef  <= $signed(tbl_q);
                        r_h     <= 49'(xs) - 49'(xp2);
                        r_y1    <= yrd;
                        r_sec   <= '0;
                        r_state <= S_ML;
                    end
                    S_ML: begin
                        if (r_k == 2'd1 || r_k == 2'd2) begin
                            r_sec <= r_sec + 56'(q);
                        end
                        r_state <= S_MH;
                    end
                    S_MH: begin
                        r_state <= S_AC;
                    end
                    S_AC: begin
                        case (r_k)
                            2'd0: begin
                                r_coef  <= $signed(tbl_q);
                                r_h     <= 49'(r_y1);
                                r_y2    <= yrd;
                                r_k     <= 2'd1;
                                r_state <= S_ML;
                            end
                            2'd1: begin
                                r_coef  <= $signed(tbl_q);
                                r_h     <= 49'(r_y2);
                                r_k     <= 2'd2;
                                r_state <= S_ML;
                            end
                            2'd2: begin
                                r_state <= S_Y;
                            end
                            default: begin
                                r_state <= S_SUM;
                            end
                        endcase
                    end
                    S_Y: begin
                        r_coef  <= $signed(tbl_q);
                        r_h     <= 49'(y_new);
                        r_k     <= 2'd3;
                        r_state <= S_ML;
                    end
                    S_SUM: begin
                        r_acc <= r_acc + 64'(q);
                        if (r_band != last_band) begin
                            r_band  <= r_band + BAND_W'(1);
                            r_state <= S_RD;
                        end else if (!r_pass && r_extra) begin
                            r_pass  <= 1'b1;
                            r_band  <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_DRY;
                        end
                    end
                    S_DRY: begin
                        r_acc   <= r_acc + dry;
                        r_state <= S_FIN;
                    end
                    S_FIN: begin
                        if (!r_ch) begin
                            r_res_l <= fin_val;
                            r_ch    <= 1'b1;
                            r_pass  <= 1'b0;
                            r_band  <= '0;
                            r_acc   <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_res_r <= fin_val;
                            r_state <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        if (out_free) begin
                            r_out.left_out           <= r_res_l;
                            r_out.right_out          <= r_res_r;
                            r_out.last_of_buffer_out <= r_last;
                            r_phase <= (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_out;
endmodule
`default_nettype wire

### hdl/geq_chk.sv
`default_nettype none
`include "assert_macros.svh"
module geq_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire geq_pkg::t_in_word  i_word,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire geq_pkg::t_out_word o_word
);
    import geq_pkg::*;

    logic smp_in, tbl_in;
    assign smp_in = i_valid && !o_stall && (i_word.action == ACT_SAMPLE);
    assign tbl_in = i_valid && !o_stall && (i_word.action == ACT_TABLE);

    `GEQ_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_word), "result word changed while stalled")
    `GEQ_ASSERT(a_busy_after_sample, smp_in |=> o_stall, "sample pair taken but input not held off")
    `GEQ_ASSERT(a_table_one_cycle, tbl_in |=> !o_stall, "table word held off the next input")
    `GEQ_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid, "result word right after reset")
endmodule

bind graphic_equalizer_iir_bank geq_chk u_geq_chk (.*);
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
module tb;
    import geq_pkg::*;

    // Longest single item is a 31-band pair through both passes.
    localparam int PAIR_CYCLES = 2100;
    // Longest stretch with no word moving: receiver hold-off + one pair + idle pause.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_word = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_word;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_idx = 1'b0;
    logic      i_cfg_data = 1'b0;

    graphic_equalizer_iir_bank dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Equalizer model state: coefficient table, both passes' histories,
    // the three-slot ring phase and the two config bits.
    // ------------------------------------------------------------------
    longint eq_coef [TBL_DEPTH];
    longint x1_hist [MAX_BANDS][2][3];
    longint y1_hist [MAX_BANDS][2][3];
    longint x2_hist [MAX_BANDS][2][3];
    longint y2_hist [MAX_BANDS][2][3];
    int     slot_phase;
    bit     wide_mode;      // 31 bands when set
    bit     second_pass;

    t_out_word eq_expected[$];
    int        fails;
    bit        hold_req;    // asks the receiver for one long hold-off
    int        idle_cycles;

    function automatic longint clip48(longint v);
        if (v > longint'(HIST_MAX)) return longint'(HIST_MAX);
        if (v < longint'(HIST_MIN)) return longint'(HIST_MIN);
        return v;
    endfunction

    // Q3.28 coefficient times Q.16 history, rounded half up back to Q.16.
    function automatic longint coef_mul(longint c, longint h);
        logic signed [95:0] a, b, p;
        a = c;
        b = h;
        p = a * b + (96'sd1 <<< 27);
        return longint'(p >>> 28);
    endfunction

    function automatic void clear_hist();
        foreach (x1_hist[b, c, s]) begin
            x1_hist[b][c][s] = 0;
            y1_hist[b][c][s] = 0;
            x2_hist[b][c][s] = 0;
            y2_hist[b][c][s] = 0;
        end
    endfunction

    // One bandpass section; returns the gain-weighted band output.
    function automatic longint run_band(bit pass2, int b, int ch, longint xin,
                                        int cur, int prev, int prev2);
        longint xn, xo, y1, y2, y;
        xn = clip48(xin);
        if (pass2) begin
            x2_hist[b][ch][cur] = xn;
            xo = x2_hist[b][ch][prev2];
            y1 = y2_hist[b][ch][prev];
            y2 = y2_hist[b][ch][prev2];
        end else begin
            x1_hist[b][ch][cur] = xn;
            xo = x1_hist[b][ch][prev2];
            y1 = y1_hist[b][ch][prev];
            y2 = y1_hist[b][ch][prev2];
        end
        y = coef_mul(eq_coef[b*4 + W_ALPHA], xn - xo)
            + coef_mul(eq_coef[b*4 + W_GAMMA], y1)
            - coef_mul(eq_coef[b*4 + W_BETA], y2);
        y = clip48(y);
        if (pass2) y2_hist[b][ch][cur] = y;
        else       y1_hist[b][ch][cur] = y;
        return coef_mul(eq_coef[b*4 + W_GAIN], y);
    endfunction

    function automatic logic signed [15:0] to_pcm(longint acc);
        if (acc < longint'(OUT_LO)) return -16'sd32768;
        if (acc > longint'(OUT_HI)) return 16'sd32767;
        return 16'(longint'((acc + longint'(HALF)) >>> HIST_FRAC));
    endfunction

    // Applies one accepted word; queues the equalized pair when there is one.
    function automatic void equalize(t_in_word w);
        longint smp, acc;
        int nb, cur, prev, prev2;
        t_out_word r;
        if (w.action == ACT_TABLE) begin
            if (w.band_index < MAX_BANDS)
                eq_coef[w.band_index*4 + w.word_select] = longint'(w.word_value);
            return;
        end
        nb = wide_mode ? BANDS_HI : BANDS_LO;
        cur = slot_phase;
        prev = (cur + 2) % 3;
        prev2 = (cur + 1) % 3;
        for (int ch = 0; ch < 2; ch++) begin
            smp = (ch == 0) ? longint'(w.left_sample) : longint'(w.right_sample);
            smp = smp <<< HIST_FRAC;
            acc = 0;
            for (int b = 0; b < nb; b++)
                acc += run_band(1'b0, b, ch, smp, cur, prev, prev2);
            if (second_pass)
                for (int b = 0; b < nb; b++)
                    acc += run_band(1'b1, b, ch, acc, cur, prev, prev2);
            acc += smp >>> 2;   // dry quarter
            if (ch == 0) r.left_out = to_pcm(acc);
            else         r.right_out = to_pcm(acc);
        end
        r.last_of_buffer_out = w.last_of_buffer;
        slot_phase = (cur + 1) % 3;
        eq_expected.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (eq_expected.size() == 0) begin
                $display("%0t: unexpected result word %p", $time, o_word);
                fails++;
            end else begin
                t_out_word e;
                e = eq_expected.pop_front();
                if (o_word.left_out !== e.left_out) begin
                    $display("%0t: left_out exp %0d act %0d", $time, e.left_out,
                             o_word.left_out);
                    fails++;
                end
                if (o_word.right_out !== e.right_out) begin
                    $display("%0t: right_out exp %0d act %0d", $time, e.right_out,
                             o_word.right_out);
                    fails++;
                end
                if (o_word.last_of_buffer_out !== e.last_of_buffer_out) begin
                    $display("%0t: last_of_buffer_out exp %0b act %0b", $time,
                             e.last_of_buffer_out, o_word.last_of_buffer_out);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall style drawn at random and redrawn over the run; one long hold-off
    // on request so the output register fills and input backs up.
    // ------------------------------------------------------------------
    initial begin
        int style;
        style = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall = 1'b0;
            end else begin
                if (($time / 10) % 256 == 0) style = $urandom_range(0, 3);
                case (style)
                    0: i_stall = 1'b0;
                    1: i_stall = ($urandom_range(0, 3) == 0);
                    2: i_stall = ($urandom_range(0, 3) != 0);
                    default: i_stall = ~i_stall;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int burst_left;

    task automatic send_word(t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_word = w;
        do @(posedge i_clk); while (o_stall);
        equalize(w);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (eq_expected.size() == 0);
    endtask

    // Register writes only with the block idle and a pair's worth of margin.
    task automatic write_reg(logic idx, logic val);
        drain();
        repeat (PAIR_CYCLES) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_BAND_MODE) begin
            wide_mode = val;
            clear_hist();
        end else begin
            second_pass = val;
        end
    endtask

    // Coefficients that keep each section stable, so outputs stay musical.
    function automatic logic signed [31:0] sane_coef(logic [1:0] sel);
        case (sel)
            W_ALPHA: return $urandom_range(0, 1 << 26);
            W_BETA:  return $urandom_range(1 << 27, 255 << 20);
            W_GAMMA: return $signed($urandom_range(0, 3 << 28)) - (3 << 27);
            default: return $signed($urandom_range(0, 1 << 29)) - (1 << 28);
        endcase
    endfunction

    function automatic t_in_word table_word(int band, logic [1:0] sel,
                                            logic signed [31:0] val);
        t_in_word w;
        w = '0;
        w.action = ACT_TABLE;
        w.left_sample = 16'($urandom);
        w.right_sample = 16'($urandom);
        w.last_of_buffer = 1'($urandom);
        w.band_index = 5'(band);
        w.word_select = sel;
        w.word_value = val;
        return w;
    endfunction

    function automatic t_in_word pair_word(logic signed [15:0] l, logic signed [15:0] r,
                                           logic last);
        t_in_word w;
        w = '0;
        w.action = ACT_SAMPLE;
        w.left_sample = l;
        w.right_sample = r;
        w.last_of_buffer = last;
        w.band_index = 5'($urandom);
        w.word_select = 2'($urandom);
        w.word_value = $urandom;
        return w;
    endfunction

    function automatic t_in_word random_word();
        logic [1:0] sel;
        if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 9) == 0)
                return pair_word($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                                 $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                                 1'($urandom));
            return pair_word(16'($urandom), 16'($urandom), 1'($urandom));
        end
        sel = 2'($urandom);
        return table_word($urandom_range(0, 31), sel,
                          ($urandom_range(0, 6) == 0) ? $urandom : sane_coef(sel));
    endfunction

    typedef struct {
        t_in_word  w;
        bit        known;   // result typed in below
        t_out_word res;
    } t_step;

    t_step steps[$];

    task automatic add_step(t_in_word w, bit known, int l, int r);
        t_step s;
        s.w = w;
        s.known = known;
        s.res.left_out = 16'(l);
        s.res.right_out = 16'(r);
        s.res.last_of_buffer_out = w.last_of_buffer;
        steps.push_back(s);
    endtask

    typedef struct {
        bit mode;
        bit extra;
        int pairs;
    } t_phase;

    initial begin
        t_phase plan[5];
        int pairs;
        int words;
        t_in_word w;

        foreach (eq_coef[i]) eq_coef[i] = 0;
        clear_hist();
        slot_phase = 0;
        wide_mode = 0;
        second_pass = 0;
        fails = 0;
        hold_req = 0;
        burst_left = 0;
        idle_cycles = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the whole table before any pair reads it; gains zero so only
        // the dry quarter reaches the output in the first directed rows.
        for (int b = 0; b < MAX_BANDS; b++)
            for (int s = 0; s < 4; s++)
                send_word(table_word(b, s[1:0],
                                     (s[1:0] == W_GAIN) ? 32'sd0 : sane_coef(s[1:0])));

        // Dry-only rows: out = floor(s/4 + 1/2).
        add_step(pair_word(16'sh7FFF, 16'sh8000, 1'b1), 1, 8192, -8192);
        add_step(pair_word(16'sh8000, 16'sh7FFF, 1'b0), 1, -8192, 8192);
        add_step(pair_word(16'sd0, 16'sd0, 1'b1), 1, 0, 0);
        add_step(pair_word(16'sd1, -16'sd1, 1'b0), 1, 0, 0);
        add_step(pair_word(16'sd2, -16'sd2, 1'b1), 1, 1, 0);
        add_step(pair_word(16'sd6, -16'sd6, 1'b0), 1, 2, -1);
        // Out-of-range band: ignored, so the dry-only result holds.
        add_step(table_word(31, W_GAIN, 32'sh7FFF_FFFF), 0, 0, 0);
        add_step(pair_word(16'sd100, -16'sd100, 1'b0), 1, 25, -25);
        // Extreme words on band 0 drive histories into saturation.
        add_step(table_word(0, W_ALPHA, 32'sh7FFF_FFFF), 0, 0, 0);
        add_step(table_word(0, W_BETA, 32'sh8000_0000), 0, 0, 0);
        add_step(table_word(0, W_GAMMA, 32'sh7FFF_FFFF), 0, 0, 0);
        add_step(table_word(0, W_GAIN, 32'sh7FFF_FFFF), 0, 0, 0);
        add_step(pair_word(16'sh7FFF, 16'sh8000, 1'b1), 0, 0, 0);
        add_step(pair_word(16'sh8000, 16'sh7FFF, 1'b0), 0, 0, 0);
        add_step(pair_word(16'sh7FFF, 16'sh7FFF, 1'b1), 0, 0, 0);
        add_step(table_word(0, W_GAIN, 32'sh8000_0000), 0, 0, 0);
        add_step(pair_word(16'sh8000, 16'sh8000, 1'b0), 0, 0, 0);
        add_step(pair_word(16'sd1234, -16'sd4321, 1'b1), 0, 0, 0);
        // Back to a tame band 0.
        add_step(table_word(0, W_ALPHA, 32'sd1 <<< 25), 0, 0, 0);
        add_step(table_word(0, W_BETA, 32'sd3 <<< 26), 0, 0, 0);
        add_step(table_word(0, W_GAMMA, 32'sd1 <<< 27), 0, 0, 0);
        add_step(table_word(0, W_GAIN, 32'sd1 <<< 27), 0, 0, 0);
        add_step(pair_word(16'sd5000, -16'sd5000, 1'b0), 0, 0, 0);

        foreach (steps[i]) begin
            send_word(steps[i].w);
            // A typed-in result replaces the model's for that row.
            if (steps[i].known) eq_expected[$] = steps[i].res;
        end

        plan[0] = '{0, 0, 300};
        plan[1] = '{1, 0, 100};
        plan[2] = '{0, 1, 170};
        plan[3] = '{1, 1, 70};
        plan[4] = '{1, 0, 30};   // same mode again: still clears histories
        foreach (plan[p]) begin
            write_reg(CFG_BAND_MODE, plan[p].mode);
            write_reg(CFG_EXTRA, plan[p].extra);
            pairs = 0;
            words = 0;
            while (pairs < plan[p].pairs) begin
                w = random_word();
                send_word(w);
                words++;
                if (w.action == ACT_SAMPLE) pairs++;
                if (p == 0 && words == 60) hold_req = 1'b1;
                if (p == 0 && words == 150) drain();
            end
        end

        drain();
        repeat (PAIR_CYCLES) @(negedge i_clk);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
